/* rtl/core/taylor_sin_cos_tan_degrees_top_assert.svh */
// Assertion macros for the trig pipeline
`ifndef TAYLOR_SIN_COS_TAN_DEGREES_TOP_ASSERT_SVH
`define TAYLOR_SIN_COS_TAN_DEGREES_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TSCT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSCT_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSCT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TSCT_ASSERT_RST(label, clk, rst_n, prop, msg)
`endif
`endif

/* rtl/core/tsct_pkg.sv */
// Shared constants and types for the degree trig pipeline
`timescale 1ns / 1ps
package tsct_pkg;
  localparam int AngleW = 22;
  localparam int SeriesTermsDef = 10;
  localparam logic [15:0] TurnUnits = 16'd46080;
  localparam logic [13:0] QuadUnits = 14'd11520;
  localparam logic [31:0] PiQ30 = 32'hC90FDAA2;
  localparam logic [31:0] OneQ30 = 32'h40000000;
  localparam int DivSteps = 47;

  typedef logic [1:0] quad_t;

  // Divisor of the i-th Taylor term, as used in the reference scaling.
  function automatic logic [9:0] term_den(input int i, input logic odd);
    int a;
    begin
      a = 2 * i;
      term_den = odd ? 10'(a * (a + 1)) : 10'((a - 1) * a);
    end
  endfunction
endpackage

/* rtl/core/tsct_reduce.sv */
// Angle reduction to quadrant and radian offset, three stages
`timescale 1ns / 1ps
module tsct_reduce
  import tsct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [AngleW-1:0] angle,
  output logic              out_v,
  output quad_t             quad,
  output logic [31:0]       x_q30
);
  localparam logic [31:0] HalfTurn = 32'(2 * QuadUnits);
  // PiQ30 = HalfTurn * PiStep + PiRem, so off * PiQ30 splits into two short products
  localparam logic [17:0] PiStep = 18'(PiQ30 / HalfTurn);
  localparam logic [14:0] PiRem = 15'(PiQ30 % HalfTurn);
  // 2^25 / 45 rounded up: exact quotient for any dividend below 2^19
  localparam logic [19:0] Recip45 = 20'd745655;

  logic        v1_r, v2_r, v3_r;
  logic [15:0] r_r;
  logic [1:0]  q2_r, q3_r;
  logic [31:0] whole_r;
  logic [27:0] frac_r;
  logic [15:0] r_nxt;
  logic [13:0] off_nxt;
  logic [1:0]  q_nxt;
  logic [6:0]  hi;
  logic [21:0] rem;
  logic [18:0] n9;
  logic [38:0] qf;

  // Modulo 360: quotient estimate by reciprocal, then up to two corrections.
  always_comb begin
    hi = 7'((33'(angle) * 33'd1456) >> 26);
    rem = angle - 22'(hi * TurnUnits);
    if (rem >= 22'(TurnUnits)) rem = rem - 22'(TurnUnits);
    if (rem >= 22'(TurnUnits)) rem = rem - 22'(TurnUnits);
    r_nxt = rem[15:0];
  end

  always_comb begin
    if (r_r >= 16'(3 * QuadUnits)) begin
      q_nxt = 2'd3; off_nxt = 14'(r_r - 16'(3 * QuadUnits));
    end else if (r_r >= 16'(2 * QuadUnits)) begin
      q_nxt = 2'd2; off_nxt = 14'(r_r - 16'(2 * QuadUnits));
    end else if (r_r >= 16'(QuadUnits)) begin
      q_nxt = 2'd1; off_nxt = 14'(r_r - 16'(QuadUnits));
    end else begin
      q_nxt = 2'd0; off_nxt = r_r[13:0];
    end
  end

  // Divide the remainder part by 23040 = 2^9 * 45: shift, then reciprocal of 45.
  always_comb begin
    n9 = frac_r[27:9];
    qf = 39'(n9) * 39'(Recip45);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      q2_r <= q_nxt;
      whole_r <= 32'(off_nxt) * 32'(PiStep);
      frac_r <= 28'(off_nxt) * 28'(PiRem) + 28'(QuadUnits);
      q3_r <= q2_r;
      x_q30 <= whole_r + 32'(qf[38:25]);
    end
  end
  assign out_v = v3_r;
  assign quad = q3_r;
endmodule

/* rtl/core/tsct_series.sv */
// Taylor series for sine and cosine, two stages per term
`timescale 1ns / 1ps
module tsct_series
  import tsct_pkg::*;
#(
  parameter int SERIES_TERMS = SeriesTermsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  quad_t       in_quad,
  input  logic [31:0] x,
  output logic        out_v,
  output quad_t       out_quad,
  output logic [30:0] s_q30,
  output logic [30:0] c_q30
);
  localparam int N = SERIES_TERMS;
  // stage 0 forms x2; term k (1..N-1) takes a product stage, then a scale-and-add stage
  logic        v_r  [N];
  quad_t       q_r  [N];
  logic [31:0] x2_r [N];
  logic [31:0] st_r [N];
  logic [31:0] ct_r [N];
  logic signed [34:0] ss_r [N];
  logic signed [34:0] cs_r [N];
  logic        pv_r   [1:N-1];
  quad_t       pq_r   [1:N-1];
  logic [31:0] px2_r  [1:N-1];
  logic [31:0] pn_s_r [1:N-1];
  logic [31:0] pn_c_r [1:N-1];
  logic signed [34:0] pss_r [1:N-1];
  logic signed [34:0] pcs_r [1:N-1];
  logic [63:0] sq;
  assign sq = 64'(x) * 64'(x) + 64'h20000000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= in_quad;
      x2_r[0] <= sq[61:30];
      st_r[0] <= x;
      ct_r[0] <= OneQ30;
      ss_r[0] <= 35'(x);
      cs_r[0] <= 35'(OneQ30);
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_term
    localparam logic [9:0] Ds = term_den(k, 1'b1);
    localparam logic [9:0] Dc = term_den(k, 1'b0);
    localparam int Ls = $clog2(Ds);
    localparam int Lc = $clog2(Dc);
    // Rounded-up reciprocals, exact for any 32-bit dividend
    localparam logic [32:0] Ms = 33'(((65'd1 << (32 + Ls)) + 65'(Ds) - 65'd1) / 65'(Ds));
    localparam logic [32:0] Mc = 33'(((65'd1 << (32 + Lc)) + 65'(Dc) - 65'd1) / 65'(Dc));
    logic [63:0] ps, pc;
    logic [64:0] qs, qc;
    logic [31:0] ns, nc;
    assign ps = 64'(st_r[k-1]) * 64'(x2_r[k-1]) + (64'(Ds) << 29);
    assign pc = 64'(ct_r[k-1]) * 64'(x2_r[k-1]) + (64'(Dc) << 29);
    assign qs = 65'(pn_s_r[k]) * 65'(Ms);
    assign qc = 65'(pn_c_r[k]) * 65'(Mc);
    assign ns = 32'(qs >> (32 + Ls));
    assign nc = 32'(qc >> (32 + Lc));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[k] <= 1'b0;
        v_r[k] <= 1'b0;
      end else if (en) begin
        pv_r[k] <= v_r[k-1];
        v_r[k] <= pv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pq_r[k] <= q_r[k-1];
        px2_r[k] <= x2_r[k-1];
        pn_s_r[k] <= ps[61:30];
        pn_c_r[k] <= pc[61:30];
        pss_r[k] <= ss_r[k-1];
        pcs_r[k] <= cs_r[k-1];
        q_r[k] <= pq_r[k];
        x2_r[k] <= px2_r[k];
        st_r[k] <= ns;
        ct_r[k] <= nc;
        ss_r[k] <= (k % 2 == 1) ? pss_r[k] - 35'(ns) : pss_r[k] + 35'(ns);
        cs_r[k] <= (k % 2 == 1) ? pcs_r[k] - 35'(nc) : pcs_r[k] + 35'(nc);
      end
    end
  end

  function automatic logic [30:0] clampq(input logic signed [34:0] v);
    begin
      if (v < 0) clampq = '0;
      else if (v > 35'sd1073741824) clampq = 31'(OneQ30);
      else clampq = v[30:0];
    end
  endfunction

  assign out_v = v_r[N-1];
  assign out_quad = q_r[N-1];
  assign s_q30 = clampq(ss_r[N-1]);
  assign c_q30 = clampq(cs_r[N-1]);
endmodule

/* rtl/core/tsct_divide.sv */
// Quadrant mapping and pipelined tangent divider, one quotient bit a stage
`timescale 1ns / 1ps
module tsct_divide
  import tsct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  quad_t       in_quad,
  input  logic [30:0] s_q30,
  input  logic [30:0] c_q30,
  output logic        out_v,
  output logic [15:0] sine_value,
  output logic [15:0] cosine_value,
  output logic [31:0] tangent_value,
  output logic        tangent_overflow
);
  localparam int NW = 47;
  localparam int K = DivSteps;
  logic        v_r   [K+1];
  logic [46:0] rem_r [K+1];
  logic [46:0] qt_r  [K+1];
  logic [30:0] den_r [K+1];
  logic [46:0] num_r [K+1];
  logic [15:0] sv_r  [K+1];
  logic [15:0] cv_r  [K+1];
  logic        tn_r  [K+1];
  logic        sn_r  [K+1];
  logic        cz_r  [K+1];

  logic [30:0] sn30, cs30;
  logic        sneg, cneg;
  logic [14:0] sq14, cq14;
  always_comb begin
    case (in_quad)
      2'd0: begin sn30 = s_q30; cs30 = c_q30; sneg = 1'b0; cneg = 1'b0; end
      2'd1: begin sn30 = c_q30; cs30 = s_q30; sneg = 1'b0; cneg = 1'b1; end
      2'd2: begin sn30 = s_q30; cs30 = c_q30; sneg = 1'b1; cneg = 1'b1; end
      default: begin sn30 = c_q30; cs30 = s_q30; sneg = 1'b1; cneg = 1'b0; end
    endcase
    sq14 = 15'((32'(sn30) + 32'h8000) >> 16);
    cq14 = 15'((32'(cs30) + 32'h8000) >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= K; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int k = 1; k <= K; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0] <= (47'(sn30) << 16) + 47'(cs30 >> 1);
      den_r[0] <= cs30;
      rem_r[0] <= '0;
      qt_r[0] <= '0;
      sv_r[0] <= sneg ? 16'(-$signed({1'b0, sq14})) : 16'(sq14);
      cv_r[0] <= cneg ? 16'(-$signed({1'b0, cq14})) : 16'(cq14);
      tn_r[0] <= in_quad[0];
      sn_r[0] <= sneg;
      cz_r[0] <= (cq14 == '0);
    end
  end

  for (genvar k = 1; k <= K; k++) begin : g_div
    logic [47:0] tr;
    assign tr = {rem_r[k-1], num_r[k-1][NW-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (tr >= 48'(den_r[k-1])) begin
          rem_r[k] <= 47'(tr - 48'(den_r[k-1]));
          qt_r[k] <= qt_r[k-1] | (47'd1 << (NW - k));
        end else begin
          rem_r[k] <= tr[46:0];
          qt_r[k] <= qt_r[k-1];
        end
        num_r[k] <= num_r[k-1]; den_r[k] <= den_r[k-1];
        sv_r[k] <= sv_r[k-1]; cv_r[k] <= cv_r[k-1];
        tn_r[k] <= tn_r[k-1]; sn_r[k] <= sn_r[k-1]; cz_r[k] <= cz_r[k-1];
      end
    end
  end

  logic [46:0] mag;
  logic        neg, ovf;
  logic [31:0] tm;
  always_comb begin
    mag = qt_r[K];
    if (cz_r[K]) begin
      ovf = 1'b1; neg = sn_r[K];
      tm = neg ? 32'h80000000 : 32'h7FFFFFFF;
    end else begin
      neg = tn_r[K]; ovf = 1'b0; tm = mag[31:0];
      if (neg && mag > 47'h80000000) begin tm = 32'h80000000; ovf = 1'b1; end
      else if (!neg && mag > 47'h7FFFFFFF) begin tm = 32'h7FFFFFFF; ovf = 1'b1; end
    end
  end

  assign out_v = v_r[K];
  assign sine_value = sv_r[K];
  assign cosine_value = cv_r[K];
  assign tangent_value = (neg && tm != '0) ? 32'(-tm) : tm;
  assign tangent_overflow = ovf;
endmodule

/* rtl/core/taylor_sin_cos_tan_degrees_top.sv */
// Top level of the degree sine, cosine and tangent pipeline
`timescale 1ns / 1ps
// One angle enters per cycle while the receiver keeps up. Each angle passes three
// reduction stages, one stage to square the offset and two per further series
// term, a quadrant stage, 47 one-bit divider stages and the output register.
// A stall freezes the whole pipe while the output register holds a word the
// receiver has not taken; the input is then held off as well.
`include "taylor_sin_cos_tan_degrees_top_assert.svh"
module taylor_sin_cos_tan_degrees_top
  import tsct_pkg::*;
#(
  parameter int SERIES_TERMS = SeriesTermsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // angle_deg[21:0], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // sine_value, cosine_value, tangent_value,
                                  // tangent_overflow, zero pad
);
  logic        en;
  logic        rv, sv, dv;
  quad_t       rq, sq;
  logic [31:0] x;
  logic [30:0] s30, c30;
  logic [15:0] sinv, cosv;
  logic [31:0] tanv;
  logic        ovf;
  logic        hold_v_r;
  logic [64:0] hold_d_r;

  // Advance while the output register is empty or being drained.
  assign en = !hold_v_r || out_tready;
  assign in_tready = en;

  tsct_reduce u_red (.clk, .rst_n, .en, .in_v(in_tvalid), .angle(in_tdata[21:0]),
    .out_v(rv), .quad(rq), .x_q30(x));
  tsct_series #(.SERIES_TERMS(SERIES_TERMS)) u_ser (.clk, .rst_n, .en, .in_v(rv),
    .in_quad(rq), .x, .out_v(sv), .out_quad(sq), .s_q30(s30), .c_q30(c30));
  tsct_divide u_div (.clk, .rst_n, .en, .in_v(sv), .in_quad(sq), .s_q30(s30),
    .c_q30(c30), .out_v(dv), .sine_value(sinv), .cosine_value(cosv),
    .tangent_value(tanv), .tangent_overflow(ovf));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (en) begin
      hold_v_r <= dv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) hold_d_r <= {ovf, tanv, cosv, sinv};
  end

  assign out_tvalid = hold_v_r;
  assign out_tdata = {7'd0, hold_d_r};

  `TSCT_ASSERT_IMPL(a_stall_hold, clk, rst_n,
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "word lost")
  `TSCT_ASSERT_IMPL(a_ready, clk, rst_n, (!out_tvalid) |-> in_tready, "pipe stuck")
  `TSCT_ASSERT_RST(a_reset, clk, rst_n, (!rst_n) |=> !out_tvalid, "valid after reset")
endmodule

/* test/tb.sv */
// Testbench for the degree sine, cosine and tangent pipeline
`timescale 1ns / 1ps
module tb;
  import tsct_pkg::*;

  localparam int NumRandom = 650;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 120;

  typedef struct packed {
    logic        ovf;
    logic [31:0] tan_v;
    logic [15:0] cos_v;
    logic [15:0] sin_v;
  } trig_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  always #2 clk = ~clk;

  taylor_sin_cos_tan_degrees_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [21:0] angle_q[$];
  trig_word_t  trig_expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_out = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // Sum of the series terms in Q30, saturated to [0, 1.0].
  function automatic logic [63:0] taylor_sum(logic [63:0] first, logic [63:0] x2, bit odd);
    logic signed [65:0] acc;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] d;
    acc = 0;
    t = first;
    for (int i = 0; i < SeriesTermsDef; i++) begin
      if (i > 0) begin
        a = 2 * i;
        d = odd ? a * (a + 1) : (a - 1) * a;
        t = (t * x2 + (d << 29)) / (d << 30);
      end
      if (i & 1) acc = acc - $signed({2'b0, t});
      else acc = acc + $signed({2'b0, t});
    end
    if (acc < 0) acc = 0;
    if (acc > 66'sh40000000) acc = 66'sh40000000;
    return acc[63:0];
  endfunction

  function automatic trig_word_t trig_of_angle(logic [21:0] ang);
    logic [63:0] r, off, x, x2, s, c, s30, c30, sq, cq, mag;
    logic [1:0] quad;
    bit sneg, cneg, tneg, ovf;
    trig_word_t w;
    r = ang % 46080;
    quad = r / 11520;
    off = r % 11520;
    x = (off * 64'hC90FDAA2 + 11520) / 23040;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    s = taylor_sum(x, x2, 1'b1);
    c = taylor_sum(64'h40000000, x2, 1'b0);
    ovf = 1'b0;
    if (quad[0]) begin
      s30 = c; c30 = s;
    end else begin
      s30 = s; c30 = c;
    end
    sneg = quad[1];
    cneg = (quad == 2'd1) || (quad == 2'd2);
    tneg = quad[0];
    sq = (s30 + 64'h8000) >> 16;
    cq = (c30 + 64'h8000) >> 16;
    if (cq == 0) begin
      ovf = 1'b1;
      tneg = sneg;
      mag = sneg ? 64'h80000000 : 64'h7FFFFFFF;
    end else begin
      mag = ((s30 << 16) + (c30 >> 1)) / c30;
      if (tneg && mag > 64'h80000000) begin
        mag = 64'h80000000; ovf = 1'b1;
      end else if (!tneg && mag > 64'h7FFFFFFF) begin
        mag = 64'h7FFFFFFF; ovf = 1'b1;
      end
    end
    w.sin_v = sneg ? 16'(-sq) : 16'(sq);
    w.cos_v = cneg ? 16'(-cq) : 16'(cq);
    w.tan_v = tneg ? 32'(-mag) : 32'(mag);
    w.ovf = ovf;
    return w;
  endfunction

  // Driver: hold the word until accepted, insert random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        trig_expected_q.push_back(trig_of_angle(in_tdata[21:0]));
        void'(angle_q.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else if (angle_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, angle_q[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin
    trig_word_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[64:0];
        if (trig_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", got);
        end else begin
          want = trig_expected_q.pop_front();
          if (got !== want || out_tdata[71:65] !== 7'd0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: sin %h/%h cos %h/%h tan %h/%h ovf %b/%b",
                       got.sin_v, want.sin_v, got.cos_v, want.cos_v,
                       got.tan_v, want.tan_v, got.ovf, want.ovf);
          end
        end
      end
      if (hold_out) out_tready <= 1'b0;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_out) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [21:0] special[$];
    special = '{22'd0, 22'd46080, 22'd92160, 22'd11520, 22'd23040, 22'd34560,
                22'd11519, 22'd11521, 22'd11600, 22'd23039, 22'd34559, 22'd34561,
                22'd46079, 22'd5760, 22'd17280, 22'd1, 22'h3FFFFF, 22'h2AAAAA,
                22'h155555, 22'd45990, 22'd11500};
    foreach (special[i]) angle_q.push_back(special[i]);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Long hold-off on the result side while angles keep coming.
    for (int i = 0; i < 150; i++) angle_q.push_back(22'($urandom_range(0, 46079)));
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk);
    hold_out <= 1'b0;
    for (int i = 0; i < NumRandom - 150; i++) begin
      case ($urandom_range(0, 3))
        0: angle_q.push_back(22'($urandom));
        1: angle_q.push_back(22'($urandom_range(0, 46079)));
        2: angle_q.push_back(22'(11520 * $urandom_range(0, 363) + $urandom_range(0, 3)
                               - $urandom_range(0, 3)));
        default: angle_q.push_back(22'($urandom_range(0, 91) * 46080
                                      + $urandom_range(0, 46079)));
      endcase
      if (i == NumRandom - 250) quiet <= 1'b1;
      while (angle_q.size() > 40) @(posedge clk);
    end
    while (angle_q.size() > 0 || in_tvalid) @(posedge clk);
    while (trig_expected_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && trig_expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tsct_pkg.sv
rtl/core/tsct_reduce.sv
rtl/core/tsct_series.sv
rtl/core/tsct_divide.sv
rtl/core/taylor_sin_cos_tan_degrees_top.sv
test/tb.sv
